// ===== design/abs_pkg.sv =====
// Shared types and constants for the alternating-bit sender.
// Used by abs_front, abs_cmd_fifo, abs_back and alternating_bit_sender.
package abs_pkg;

    localparam int MSG_BYTES_DEF = 20;
    localparam int CFG_ADDR_W    = 3;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;
    localparam logic CFG_IDX_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        REQ_MSG  = 2'd0,
        REQ_RX   = 2'd1,
        REQ_TICK = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_DISCARD = 2'd3
    } kind_t;

    // One unit of work for the back end: a whole packet or a single status.
    typedef struct packed {
        logic        is_emit;
        kind_t       kind;
        logic        retx;
        logic        bank;
        logic        seq;
        logic        ack;
        logic [31:0] checksum;
    } cmd_t;

endpackage

// ===== design/abs_front.sv =====
// Front end of the alternating-bit sender: accepts and classifies transactions,
// keeps the protocol state and pushes commands. Depends on abs_pkg.
module abs_front #(
    parameter  int MSG_BYTES = abs_pkg::MSG_BYTES_DEF,
    localparam int IDX_W     = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [7:0]          in_byte,
    input  logic signed [31:0]  in_seq,
    input  logic signed [31:0]  in_ack,
    input  logic signed [31:0]  in_checksum,
    input  logic [15:0]         timeout_ticks,
    input  logic                fifo_full,
    input  logic [1:0]          bank_busy,
    output logic                push,
    output abs_pkg::cmd_t       push_cmd,
    output logic                wr_en,
    output logic [IDX_W:0]      wr_addr,
    output logic [7:0]          wr_data
);
    import abs_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MSG_BYTES - 1);

    logic             waiting_ack_reg, waiting_ack_next;
    logic             send_seq_reg, send_seq_next;
    logic             expect_ack_reg, expect_ack_next;
    logic             timer_running_reg, timer_running_next;
    logic [15:0]      timer_count_reg, timer_count_next;
    logic [IDX_W-1:0] stage_idx_reg, stage_idx_next;
    logic [31:0]      stage_sum_reg, stage_sum_next;
    logic             stage_bank_reg, stage_bank_next;
    logic             sent_bank_reg, sent_bank_next;
    logic             sent_seq_reg, sent_seq_next;
    logic             sent_ack_reg, sent_ack_next;
    logic [31:0]      sent_chk_reg, sent_chk_next;
    logic [IDX_W-1:0] rx_idx_reg, rx_idx_next;
    logic [31:0]      rx_sum_reg, rx_sum_next;

    logic        accept;
    logic [31:0] byte_sext;
    logic [31:0] stage_sum_new;
    logic [31:0] rx_sum_new;
    logic [31:0] pkt_chk;
    logic        rx_ok;

    always_comb begin
        byte_sext     = {{24{in_byte[7]}}, in_byte};
        stage_sum_new = stage_sum_reg + byte_sext;
        rx_sum_new    = rx_sum_reg + byte_sext;
        pkt_chk       = stage_sum_new + {31'b0, send_seq_reg} + {31'b0, ~expect_ack_reg};
        rx_ok         = waiting_ack_reg && (in_ack == {31'b0, expect_ack_reg})
                        && ((in_seq + in_ack + rx_sum_new) == in_checksum);
        // Hold message bytes while the staging bank is still read for a packet.
        in_stall      = fifo_full || ((req_type == REQ_MSG) && bank_busy[stage_bank_reg]);
        accept        = in_valid && !in_stall;
    end

    always_comb begin
        waiting_ack_next   = waiting_ack_reg;
        send_seq_next      = send_seq_reg;
        expect_ack_next    = expect_ack_reg;
        timer_running_next = timer_running_reg;
        timer_count_next   = timer_count_reg;
        stage_idx_next     = stage_idx_reg;
        stage_sum_next     = stage_sum_reg;
        stage_bank_next    = stage_bank_reg;
        sent_bank_next     = sent_bank_reg;
        sent_seq_next      = sent_seq_reg;
        sent_ack_next      = sent_ack_reg;
        sent_chk_next      = sent_chk_reg;
        rx_idx_next        = rx_idx_reg;
        rx_sum_next        = rx_sum_reg;
        push               = 1'b0;
        push_cmd           = '0;
        wr_en              = 1'b0;
        wr_addr            = {stage_bank_reg, stage_idx_reg};
        wr_data            = in_byte;

        if (accept) begin
            unique case (req_type)
                REQ_MSG:
                begin
                    wr_en = 1'b1;
                    if (stage_idx_reg == IDX_LAST) begin
                        stage_idx_next = '0;
                        stage_sum_next = '0;
                        push           = 1'b1;
                        if (waiting_ack_reg) begin
                            push_cmd.kind = KIND_REJECT;
                        end
                        else begin
                            push_cmd.is_emit   = 1'b1;
                            push_cmd.kind      = KIND_BYTE;
                            push_cmd.bank      = stage_bank_reg;
                            push_cmd.seq       = send_seq_reg;
                            push_cmd.ack       = ~expect_ack_reg;
                            push_cmd.checksum  = pkt_chk;
                            sent_bank_next     = stage_bank_reg;
                            sent_seq_next      = send_seq_reg;
                            sent_ack_next      = ~expect_ack_reg;
                            sent_chk_next      = pkt_chk;
                            stage_bank_next    = ~stage_bank_reg;
                            waiting_ack_next   = 1'b1;
                            send_seq_next      = ~send_seq_reg;
                            timer_running_next = 1'b1;
                            timer_count_next   = timeout_ticks;
                        end
                    end
                    else begin
                        stage_idx_next = stage_idx_reg + 1'b1;
                        stage_sum_next = stage_sum_new;
                    end
                end
                REQ_RX:
                begin
                    if (rx_idx_reg == IDX_LAST) begin
                        rx_idx_next = '0;
                        rx_sum_next = '0;
                        push        = 1'b1;
                        if (rx_ok) begin
                            push_cmd.kind      = KIND_ACK;
                            timer_running_next = 1'b0;
                            timer_count_next   = '0;
                            expect_ack_next    = ~expect_ack_reg;
                            waiting_ack_next   = 1'b0;
                        end
                        else begin
                            push_cmd.kind = KIND_DISCARD;
                        end
                    end
                    else begin
                        rx_idx_next = rx_idx_reg + 1'b1;
                        rx_sum_next = rx_sum_new;
                    end
                end
                REQ_TICK:
                begin
                    if (timer_running_reg) begin
                        if (timer_count_reg > 16'd1) begin
                            timer_count_next = timer_count_reg - 16'd1;
                        end
                        else begin
                            // Expired: reload and resend the stored packet.
                            timer_count_next  = timeout_ticks;
                            push              = 1'b1;
                            push_cmd.is_emit  = 1'b1;
                            push_cmd.kind     = KIND_BYTE;
                            push_cmd.retx     = 1'b1;
                            push_cmd.bank     = sent_bank_reg;
                            push_cmd.seq      = sent_seq_reg;
                            push_cmd.ack      = sent_ack_reg;
                            push_cmd.checksum = sent_chk_reg;
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            waiting_ack_reg   <= 1'b0;
            send_seq_reg      <= 1'b0;
            expect_ack_reg    <= 1'b0;
            timer_running_reg <= 1'b0;
            timer_count_reg   <= '0;
            stage_idx_reg     <= '0;
            stage_sum_reg     <= '0;
            stage_bank_reg    <= 1'b0;
            sent_bank_reg     <= 1'b0;
            sent_seq_reg      <= 1'b0;
            sent_ack_reg      <= 1'b0;
            sent_chk_reg      <= '0;
            rx_idx_reg        <= '0;
            rx_sum_reg        <= '0;
        end
        else begin
            waiting_ack_reg   <= waiting_ack_next;
            send_seq_reg      <= send_seq_next;
            expect_ack_reg    <= expect_ack_next;
            timer_running_reg <= timer_running_next;
            timer_count_reg   <= timer_count_next;
            stage_idx_reg     <= stage_idx_next;
            stage_sum_reg     <= stage_sum_next;
            stage_bank_reg    <= stage_bank_next;
            sent_bank_reg     <= sent_bank_next;
            sent_seq_reg      <= sent_seq_next;
            sent_ack_reg      <= sent_ack_next;
            sent_chk_reg      <= sent_chk_next;
            rx_idx_reg        <= rx_idx_next;
            rx_sum_reg        <= rx_sum_next;
        end
    end

endmodule

// ===== design/abs_cmd_fifo.sv =====
// Two-entry command queue between front and back end.
// Reports which packet banks its entries still refer to. Depends on abs_pkg.
module abs_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  abs_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output abs_pkg::cmd_t head_cmd,
    output logic [1:0]    bank_busy
);
    import abs_pkg::*;

    cmd_t       ent_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;
    logic [1:0] occ;

    always_comb begin
        full       = (count_reg == 2'd2);
        head_valid = (count_reg != 2'd0);
        head_cmd   = ent_reg[rd_ptr_reg];
        do_pop     = pop && head_valid;

        occ[0] = full || (head_valid && (rd_ptr_reg == 1'b0));
        occ[1] = full || (head_valid && (rd_ptr_reg == 1'b1));
        bank_busy = '0;
        for (int i = 0; i < 2; i++) begin
            if (occ[i] && ent_reg[i].is_emit) begin
                bank_busy[ent_reg[i].bank] = 1'b1;
            end
        end

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/abs_back.sv =====
// Back end of the alternating-bit sender: owns the two-bank packet memory,
// plays out commands and drives the output register. Depends on abs_pkg.
module abs_back #(
    parameter  int MSG_BYTES = abs_pkg::MSG_BYTES_DEF,
    localparam int IDX_W     = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W:0]      wr_addr,
    input  logic [7:0]          wr_data,
    input  logic                fifo_valid,
    input  abs_pkg::cmd_t       fifo_head,
    output logic                pop,
    output logic [1:0]          bank_busy,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          out_kind,
    output logic [7:0]          out_byte,
    output logic                out_seq,
    output logic                out_ack,
    output logic signed [31:0]  out_checksum,
    output logic                out_retransmit,
    output logic                out_last
);
    import abs_pkg::*;

    localparam int               MEM_DEPTH = 2 << IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MSG_BYTES - 1);

    logic [7:0] mem [0:MEM_DEPTH-1];
    logic [7:0] rd_data_reg;

    logic             act_valid_reg;
    cmd_t             act_cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             s1_valid_reg;
    cmd_t             s1_cmd_reg;
    logic             s1_last_reg;
    logic             out_valid_reg;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_seq_reg;
    logic             out_ack_reg;
    logic [31:0]      out_chk_reg;
    logic             out_retx_reg;
    logic             out_last_reg;

    logic             adv;
    logic             act_last;
    logic             take;
    logic             rd_en;
    logic [IDX_W:0]   rd_addr;

    always_comb begin
        adv      = !out_valid_reg || !out_stall;
        act_last = act_cmd_reg.is_emit ? (idx_reg == IDX_LAST) : 1'b1;
        take     = !act_valid_reg || (adv && act_last);
        pop      = take && fifo_valid;
        rd_en    = adv && act_valid_reg && act_cmd_reg.is_emit;
        rd_addr  = {act_cmd_reg.bank, idx_reg};

        bank_busy = '0;
        if (act_valid_reg && act_cmd_reg.is_emit) begin
            bank_busy[act_cmd_reg.bank] = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            act_valid_reg <= 1'b0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (take) begin
                act_valid_reg <= fifo_valid;
                idx_reg       <= '0;
            end
            else if (adv) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (adv) begin
                s1_valid_reg  <= act_valid_reg;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (take) begin
            act_cmd_reg <= fifo_head;
        end
        if (adv) begin
            s1_cmd_reg   <= act_cmd_reg;
            s1_last_reg  <= act_last;
            out_kind_reg <= s1_cmd_reg.kind;
            out_byte_reg <= s1_cmd_reg.is_emit ? rd_data_reg : 8'd0;
            out_seq_reg  <= s1_cmd_reg.seq;
            out_ack_reg  <= s1_cmd_reg.ack;
            out_chk_reg  <= s1_cmd_reg.checksum;
            out_retx_reg <= s1_cmd_reg.retx;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_byte       = out_byte_reg;
    assign out_seq        = out_seq_reg;
    assign out_ack        = out_ack_reg;
    assign out_checksum   = out_chk_reg;
    assign out_retransmit = out_retx_reg;
    assign out_last       = out_last_reg;

endmodule

// ===== design/alternating_bit_sender.sv =====
// Top level of the alternating-bit sender: configuration register and the
// front end, command queue and back end. Depends on abs_pkg and abs_* modules.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------------------
//   input    | in        | in_valid / in_stall     | req_type in_byte in_seq in_ack
//            |           |                         | in_checksum
//   output   | out       | out_valid / out_stall   | out_kind out_byte out_seq out_ack
//            |           |                         | out_checksum out_retransmit
//            |           |                         | out_last
//   config   | in/out    | psel penable pwrite     | paddr pwdata prdata
//
// The front end takes one transaction per cycle while in_stall is low. A packet
// plays out as MSG_BYTES output transactions at one per cycle unless the output
// stalls, bounded by the single read port of the packet memory; a status result is
// one output transaction. Results pass the queue and the act, s1 and out registers.
// Reset is asynchronous and clears all control state; no memory clearing pass.
// The two-entry command queue lets the front keep accepting while the output
// is stalled; the front stalls when the queue is full, or on a message byte
// whose staging bank is still queued or being played out.
module alternating_bit_sender #(
    parameter int MSG_BYTES = abs_pkg::MSG_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      req_type,
    input  logic [7:0]                      in_byte,
    input  logic signed [31:0]              in_seq,
    input  logic signed [31:0]              in_ack,
    input  logic signed [31:0]              in_checksum,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      out_kind,
    output logic [7:0]                      out_byte,
    output logic                            out_seq,
    output logic                            out_ack,
    output logic signed [31:0]              out_checksum,
    output logic                            out_retransmit,
    output logic                            out_last,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [abs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import abs_pkg::*;

    localparam int IDX_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

    logic [15:0]    timeout_reg, timeout_next;
    logic           cfg_write;

    logic           push;
    cmd_t           push_cmd;
    logic           fifo_full;
    logic           fifo_valid;
    cmd_t           fifo_head;
    logic           pop;
    logic [1:0]     fifo_bank_busy;
    logic [1:0]     back_bank_busy;
    logic [1:0]     bank_busy;
    logic           wr_en;
    logic [IDX_W:0] wr_addr;
    logic [7:0]     wr_data;

    // Register index sits at paddr[2]; only the timeout register exists.
    always_comb begin
        pready       = 1'b1;
        cfg_write    = psel && penable && pwrite;
        timeout_next = timeout_reg;
        if (cfg_write && (paddr[2] == CFG_IDX_TIMEOUT)) begin
            timeout_next = pwdata[15:0];
        end
        prdata = (paddr[2] == CFG_IDX_TIMEOUT) ? {16'b0, timeout_reg} : 32'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else begin
            timeout_reg <= timeout_next;
        end
    end

    // A bank is busy while any queued or playing packet still reads it.
    assign bank_busy = fifo_bank_busy | back_bank_busy;

    abs_front #(
        .MSG_BYTES (MSG_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .in_byte       (in_byte),
        .in_seq        (in_seq),
        .in_ack        (in_ack),
        .in_checksum   (in_checksum),
        .timeout_ticks (timeout_reg),
        .fifo_full     (fifo_full),
        .bank_busy     (bank_busy),
        .push          (push),
        .push_cmd      (push_cmd),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    abs_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (fifo_full),
        .head_valid (fifo_valid),
        .head_cmd   (fifo_head),
        .bank_busy  (fifo_bank_busy)
    );

    abs_back #(
        .MSG_BYTES (MSG_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .fifo_valid     (fifo_valid),
        .fifo_head      (fifo_head),
        .pop            (pop),
        .bank_busy      (back_bank_busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .out_byte       (out_byte),
        .out_seq        (out_seq),
        .out_ack        (out_ack),
        .out_checksum   (out_checksum),
        .out_retransmit (out_retransmit),
        .out_last       (out_last)
    );

endmodule
